// File: rtl/tbsd_pkg.sv
`default_nettype none

package tbsd_pkg;

  localparam int unsigned NumSqrtCells = 49;
  localparam int unsigned NumDivCells  = 48;

  localparam int unsigned RadW  = 98;   // radius squared, padded to an even bit count
  localparam int unsigned RemW  = 51;   // square root remainder
  localparam int unsigned RootW = 49;   // square root result
  localparam int unsigned DW    = 146;  // cube of radius
  localparam int unsigned QW    = 48;   // quotient bits

  // square root cell state: rotating radicand, remainder, partial root
  typedef struct packed {
    logic [RadW-1:0]  rad;
    logic [RemW-1:0]  rem;
    logic [RootW-1:0] root;
  } sq_t;

  // divider cell state: partial remainder, dividend bits still to shift in, quotient
  typedef struct packed {
    logic [DW-1:0] prem;
    logic [QW-1:0] low;
    logic [QW-1:0] quo;
  } dv_t;

endpackage

`default_nettype wire

// File: rtl/tbsd_mul64.sv
`default_nettype none

module tbsd_mul64 (
  input  logic         clk_i,
  input  logic         en_i,
  input  logic [63:0]  a_i,
  input  logic [63:0]  b_i,
  output logic [127:0] prod_o
);

  logic [63:0]  pp_q [4];
  logic [127:0] prod_q;

  // stage 1: four 32x32 partial products
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      pp_q[0] <= a_i[31:0]  * b_i[31:0];
      pp_q[1] <= a_i[31:0]  * b_i[63:32];
      pp_q[2] <= a_i[63:32] * b_i[31:0];
      pp_q[3] <= a_i[63:32] * b_i[63:32];
    end
  end

  // stage 2: weighted sum
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      prod_q <= {64'd0, pp_q[0]} + {32'd0, pp_q[1], 32'd0} + {32'd0, pp_q[2], 32'd0}
                + {pp_q[3], 64'd0};
    end
  end

  assign prod_o = prod_q;

endmodule

`default_nettype wire

// File: rtl/tbsd_sqrt_cell.sv
`default_nettype none

module tbsd_sqrt_cell (
  input  logic           clk_i,
  input  logic           en_i,
  input  tbsd_pkg::sq_t  cell_i,
  output tbsd_pkg::sq_t  cell_o
);
  import tbsd_pkg::*;

  logic [RemW+1:0] rem2;
  logic [RemW+1:0] trial;
  logic [RemW+1:0] diff;
  logic            ge;
  sq_t             cell_d;
  sq_t             cell_q;

  // one root bit: bring in two radicand bits, try (root << 2) | 1
  always_comb begin
    rem2        = {cell_i.rem, cell_i.rad[RadW-1 -: 2]};
    trial       = {2'b00, cell_i.root, 2'b01};
    diff        = rem2 - trial;
    ge          = (rem2 >= trial);
    cell_d.rad  = {cell_i.rad[RadW-3:0], cell_i.rad[RadW-1 -: 2]};
    cell_d.rem  = ge ? diff[RemW-1:0] : rem2[RemW-1:0];
    cell_d.root = {cell_i.root[RootW-2:0], ge};
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      cell_q <= cell_d;
    end
  end

  assign cell_o = cell_q;

endmodule

`default_nettype wire

// File: rtl/tbsd_div_cell.sv
`default_nettype none

module tbsd_div_cell (
  input  logic                    clk_i,
  input  logic                    en_i,
  input  logic [tbsd_pkg::DW-1:0] d_i,
  input  tbsd_pkg::dv_t           cell_i,
  output tbsd_pkg::dv_t           cell_o
);
  import tbsd_pkg::*;

  logic [DW:0] p2;
  logic [DW:0] diff;
  logic        ge;
  dv_t         cell_d;
  dv_t         cell_q;

  // one restoring step; partial remainder stays below d
  always_comb begin
    p2          = {cell_i.prem, cell_i.low[QW-1]};
    diff        = p2 - {1'b0, d_i};
    ge          = (p2 >= {1'b0, d_i});
    cell_d.prem = ge ? diff[DW-1:0] : p2[DW-1:0];
    cell_d.low  = {cell_i.low[QW-2:0], 1'b0};
    cell_d.quo  = {cell_i.quo[QW-2:0], ge};
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      cell_q <= cell_d;
    end
  end

  assign cell_o = cell_q;

endmodule

`default_nettype wire

// File: rtl/two_body_state_derivative_top.sv
`default_nettype none

// Channel   Direction  Handshake               Payload
// in        input      in_valid_i/in_ready_o   pos_x_i..pos_z_i, vel_x_i..vel_z_i
// out       output     out_valid_o/out_ready_i dpos_x_o..dpos_z_o, acc_x_o..acc_z_o,
//                                              zero_radius_o
// cfg       input      cfg_we_i                cfg_wdata_i (grav_param)
//
// One transfer per cycle in, one per cycle out while out does not stall; the
// pipeline depth is set by the 49-cell square root chain and the 48-cell
// divider chains plus multiplier and prep stages.
// Reset clears the stage valid bits and loads the Earth value into grav_param.
// The whole pipeline advances only when the output register is empty or taken;
// a stall at out holds every stage and drops in_ready_o in the same cycle.
module two_body_state_derivative_top (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cfg_we_i,
  input  logic [59:0]        cfg_wdata_i,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  logic signed [47:0] pos_x_i,
  input  logic signed [47:0] pos_y_i,
  input  logic signed [47:0] pos_z_i,
  input  logic signed [39:0] vel_x_i,
  input  logic signed [39:0] vel_y_i,
  input  logic signed [39:0] vel_z_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output logic signed [39:0] dpos_x_o,
  output logic signed [39:0] dpos_y_o,
  output logic signed [39:0] dpos_z_o,
  output logic signed [47:0] acc_x_o,
  output logic signed [47:0] acc_y_o,
  output logic signed [47:0] acc_z_o,
  output logic               zero_radius_o
);
  import tbsd_pkg::*;

  // stage numbers: indices into the valid line v_q and the side line side_q
  localparam int unsigned KSum  = 3;
  localparam int unsigned KRoot = KSum + NumSqrtCells;   // root ready
  localparam int unsigned KComb = KRoot + 3;             // cube of radius assembled
  localparam int unsigned KPrep = KComb + 2;             // divider start
  localparam int unsigned KQuo  = KPrep + NumDivCells;   // quotients read by the output register
  localparam int unsigned KOut  = KQuo + 1;

  localparam logic [59:0] GravReset = 60'd398600441800000;
  localparam logic [47:0] CapPos    = 48'h7FFF_FFFF_FFFF;
  localparam logic [47:0] CapNeg    = 48'h8000_0000_0000;

  // per-item data that rides alongside the arithmetic
  typedef struct packed {
    logic [2:0][39:0] vel;
    logic [2:0][47:0] mag;
    logic [2:0]       pos_gt;   // component strictly positive
    logic [2:0]       sat;      // quotient known to overflow
    logic             zero;
  } side_t;

  logic        en;
  logic [59:0] mu_q;
  logic        v_q    [KOut+1];
  side_t       side_q [KQuo+1];
  side_t       side_d [KQuo+1];

  logic [47:0] pos_in [3];
  logic [39:0] vel_in [3];

  logic [127:0] sq_prod [3];
  sq_t          sq_c [NumSqrtCells+1];
  logic [127:0] dlo_prod;
  logic [127:0] dhi_prod;
  logic [127:0] mu_prod [3];

  logic [191:0]  d_sum;
  logic [DW-1:0] d_comb_q;
  logic [107:0]  pm_q [3];
  logic [DW-1:0] d_add_q;
  logic [108:0]  add_q [3];
  logic [QW-1:0] low_q;
  logic [2:0]    sat_c;
  logic [DW-1:0] d_q [NumDivCells];
  dv_t           dv_c [3][NumDivCells+1];

  logic [47:0] acc_q  [3];
  logic [39:0] dpos_q [3];
  logic        zero_q;

  // pipeline advances when the output register is free
  assign en          = !v_q[KOut] || out_ready_i;
  assign in_ready_o  = en;
  assign out_valid_o = v_q[KOut];

  assign pos_in[0] = pos_x_i;
  assign pos_in[1] = pos_y_i;
  assign pos_in[2] = pos_z_i;
  assign vel_in[0] = vel_x_i;
  assign vel_in[1] = vel_y_i;
  assign vel_in[2] = vel_z_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mu_q <= GravReset;
    end else if (cfg_we_i) begin
      mu_q <= cfg_wdata_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int k = 0; k <= KOut; k++) begin
        v_q[k] <= 1'b0;
      end
    end else if (en) begin
      v_q[0] <= in_valid_i;
      for (int k = 1; k <= KOut; k++) begin
        v_q[k] <= v_q[k-1];
      end
    end
  end

  // side line: velocities, magnitudes, signs and zero flag captured at input, sat flags at divider start
  always_comb begin
    for (int i = 0; i < 3; i++) begin
      side_d[0].vel[i]    = vel_in[i];
      side_d[0].mag[i]    = pos_in[i][47] ? 48'(-pos_in[i]) : pos_in[i];
      side_d[0].pos_gt[i] = !pos_in[i][47] && (pos_in[i] != '0);
      side_d[0].sat[i]    = 1'b0;
    end
    side_d[0].zero = (pos_x_i == '0) && (pos_y_i == '0) && (pos_z_i == '0);
    for (int k = 1; k <= KQuo; k++) begin
      side_d[k] = side_q[k-1];
    end
    side_d[KPrep].sat = sat_c;
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      for (int k = 0; k <= KQuo; k++) begin
        side_q[k] <= side_d[k];
      end
    end
  end

  // squares of the component magnitudes
  for (genvar i = 0; i < 3; i++) begin : g_sq
    tbsd_mul64 u_sq (
      .clk_i  (clk_i),
      .en_i   (en),
      .a_i    ({16'd0, side_q[0].mag[i]}),
      .b_i    ({16'd0, side_q[0].mag[i]}),
      .prod_o (sq_prod[i])
    );
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      sq_c[0].rad  <= {2'b00, sq_prod[0][95:0]} + {2'b00, sq_prod[1][95:0]}
                      + {2'b00, sq_prod[2][95:0]};
      sq_c[0].rem  <= '0;
      sq_c[0].root <= '0;
    end
  end

  // square root chain: one root bit per cell; the radicand rotates back whole
  for (genvar j = 0; j < NumSqrtCells; j++) begin : g_sqrt
    tbsd_sqrt_cell u_cell (
      .clk_i  (clk_i),
      .en_i   (en),
      .cell_i (sq_c[j]),
      .cell_o (sq_c[j+1])
    );
  end

  // cube of radius: S * R split at bit 64 of S
  tbsd_mul64 u_dlo (
    .clk_i  (clk_i),
    .en_i   (en),
    .a_i    (sq_c[NumSqrtCells].rad[63:0]),
    .b_i    ({15'd0, sq_c[NumSqrtCells].root}),
    .prod_o (dlo_prod)
  );

  tbsd_mul64 u_dhi (
    .clk_i  (clk_i),
    .en_i   (en),
    .a_i    ({32'd0, sq_c[NumSqrtCells].rad[95:64]}),
    .b_i    ({15'd0, sq_c[NumSqrtCells].root}),
    .prod_o (dhi_prod)
  );

  // mu times each magnitude
  for (genvar i = 0; i < 3; i++) begin : g_mu
    tbsd_mul64 u_mu (
      .clk_i  (clk_i),
      .en_i   (en),
      .a_i    ({4'd0, mu_q}),
      .b_i    ({16'd0, side_q[KRoot].mag[i]}),
      .prod_o (mu_prod[i])
    );
  end

  assign d_sum = {64'd0, dlo_prod} + {dhi_prod, 64'd0};

  // dividend = mu*m*2^48 + floor(D/2): top part mu*m + (D >> 49), low bits D[48:1]
  always_ff @(posedge clk_i) begin
    if (en) begin
      d_comb_q <= d_sum[DW-1:0];
      for (int i = 0; i < 3; i++) begin
        pm_q[i] <= mu_prod[i][107:0];
      end
      d_add_q <= d_comb_q;
      low_q   <= d_comb_q[48:1];
      for (int i = 0; i < 3; i++) begin
        add_q[i] <= {1'b0, pm_q[i]} + {12'd0, d_comb_q[DW-1:49]};
      end
    end
  end

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      sat_c[i] = ({37'd0, add_q[i]} >= d_add_q);
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      d_q[0] <= d_add_q;
      for (int j = 1; j < NumDivCells; j++) begin
        d_q[j] <= d_q[j-1];
      end
      for (int i = 0; i < 3; i++) begin
        dv_c[i][0].prem <= sat_c[i] ? '0 : {37'd0, add_q[i]};
        dv_c[i][0].low  <= low_q;
        dv_c[i][0].quo  <= '0;
      end
    end
  end

  // three divider chains sharing the divisor line
  for (genvar i = 0; i < 3; i++) begin : g_divc
    for (genvar j = 0; j < NumDivCells; j++) begin : g_cell
      tbsd_div_cell u_cell (
        .clk_i  (clk_i),
        .en_i   (en),
        .d_i    (d_q[j]),
        .cell_i (dv_c[i][j]),
        .cell_o (dv_c[i][j+1])
      );
    end
  end

  // output register: saturate, apply opposite sign, force zero radius
  always_ff @(posedge clk_i) begin
    logic [47:0] q;
    if (en) begin
      for (int i = 0; i < 3; i++) begin
        q = dv_c[i][NumDivCells].quo;
        if (side_q[KQuo].zero) begin
          acc_q[i] <= '0;
        end else if (side_q[KQuo].pos_gt[i]) begin
          if (side_q[KQuo].sat[i] || (q > CapNeg)) begin
            q = CapNeg;
          end
          acc_q[i] <= 48'(-q);
        end else begin
          if (side_q[KQuo].sat[i] || (q > CapPos)) begin
            q = CapPos;
          end
          acc_q[i] <= q;
        end
        dpos_q[i] <= side_q[KQuo].vel[i];
      end
      zero_q <= side_q[KQuo].zero;
    end
  end

  assign dpos_x_o      = dpos_q[0];
  assign dpos_y_o      = dpos_q[1];
  assign dpos_z_o      = dpos_q[2];
  assign acc_x_o       = acc_q[0];
  assign acc_y_o       = acc_q[1];
  assign acc_z_o       = acc_q[2];
  assign zero_radius_o = zero_q;

`ifndef SYNTH
  a_zero_acc: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && zero_radius_o |-> (acc_x_o == '0) && (acc_y_o == '0) && (acc_z_o == '0))
    else $error("zero radius with nonzero acceleration");

  a_sign_x: assert property (@(posedge clk_i) disable iff (!rst_ni)
    v_q[KQuo] && en && side_q[KQuo].pos_gt[0] |=> acc_x_o[47] || (acc_x_o == '0))
    else $error("acc_x not opposite to positive position");

  a_root_rem: assert property (@(posedge clk_i) disable iff (!rst_ni)
    v_q[KRoot] |-> sq_c[NumSqrtCells].rem <= {sq_c[NumSqrtCells].root, 1'b0})
    else $error("square root remainder out of range");

  a_div_start: assert property (@(posedge clk_i) disable iff (!rst_ni)
    v_q[KPrep] |-> (dv_c[0][0].prem < d_q[0]) || side_q[KPrep].zero)
    else $error("divider partial remainder not below divisor");
`endif

endmodule

`default_nettype wire
